// ----- hw/rtl/lrpsb_pkg.sv -----
// Shared types, command codes and group shift maps for the LED ring pixel buffer.
package lrpsb_pkg;

    localparam int NUM_PIXELS = 12;
    localparam int IDX_W      = 4;
    localparam int COLOR_W    = 32;
    localparam int CMD_W      = 4;

    localparam logic [IDX_W-1:0] LAST_PIXEL_IDX = IDX_W'(NUM_PIXELS - 1);
    // source code that selects the incoming color instead of a stored pixel
    localparam logic [IDX_W-1:0] SRC_NEW        = 4'd15;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR       = 4'd0,
        CMD_SET         = 4'd1,
        CMD_LINE_RIGHT  = 4'd2,
        CMD_LINE_LEFT   = 4'd3,
        CMD_COLS_RIGHT  = 4'd4,
        CMD_COLS_LEFT   = 4'd5,
        CMD_DIGIT_RIGHT = 4'd6,
        CMD_DIGIT_LEFT  = 4'd7,
        CMD_ROWS_UP     = 4'd8,
        CMD_ROWS_DOWN   = 4'd9,
        CMD_SHOW        = 4'd10
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } state_t;

    typedef logic [COLOR_W-1:0] color_t;
    typedef color_t             pix_arr_t [NUM_PIXELS];
    typedef logic [IDX_W-1:0]   src_map_t [NUM_PIXELS];

    // controller to datapath
    typedef struct packed {
        logic             apply;
        logic             emit;
        logic [IDX_W-1:0] index;
        logic             last;
    } dp_cmd_t;

    // per-pixel source for each shift, listed pixel 0 .. 11
    localparam src_map_t LINE_RIGHT_MAP  = '{SRC_NEW, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
                                             4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10};
    localparam src_map_t LINE_LEFT_MAP   = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                                             4'd7, 4'd8, 4'd9, 4'd10, 4'd11, SRC_NEW};
    localparam src_map_t COLS_RIGHT_MAP  = '{SRC_NEW, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
                                             4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
    localparam src_map_t COLS_LEFT_MAP   = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                                             SRC_NEW, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};
    localparam src_map_t DIGIT_RIGHT_MAP = '{SRC_NEW, SRC_NEW, 4'd0, 4'd0, 4'd0, 4'd2,
                                             4'd2, 4'd2, 4'd5, 4'd5, 4'd5, SRC_NEW};
    localparam src_map_t DIGIT_LEFT_MAP  = '{4'd2, 4'd2, 4'd5, 4'd5, 4'd5, 4'd8,
                                             4'd8, 4'd8, SRC_NEW, SRC_NEW, SRC_NEW, 4'd2};
    localparam src_map_t ROWS_UP_MAP     = '{4'd11, 4'd0, 4'd1, 4'd2, 4'd1, 4'd0,
                                             4'd11, 4'd10, 4'd9, SRC_NEW, 4'd9, 4'd10};
    localparam src_map_t ROWS_DOWN_MAP   = '{4'd1, 4'd2, 4'd3, SRC_NEW, 4'd3, 4'd2,
                                             4'd1, 4'd0, 4'd11, 4'd10, 4'd11, 4'd0};

endpackage

// ----- hw/rtl/lrpsb_ctrl.sv -----
// Controller: accepts commands and sequences the twelve beats of a show run.
module lrpsb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_command,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lrpsb_pkg::dp_cmd_t    dp_cmd
);

    lrpsb_pkg::state_t      state_reg, state_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lrpsb_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_ready      = 1'b0;
        dp_cmd.apply = 1'b0;
        dp_cmd.emit  = 1'b0;
        dp_cmd.index = cnt_reg;
        dp_cmd.last  = (cnt_reg == lrpsb_pkg::LAST_PIXEL_IDX);
        unique case (state_reg)
            lrpsb_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                dp_cmd.apply = s_valid;
                if (s_valid && (s_command == lrpsb_pkg::CMD_SHOW)) begin
                    state_next = lrpsb_pkg::ST_SHOW;
                    cnt_next   = '0;
                end
            end
            lrpsb_pkg::ST_SHOW: begin
                if (slot_free) begin
                    dp_cmd.emit = 1'b1;
                    cnt_next    = cnt_reg + 4'd1;
                    if (dp_cmd.last) begin
                        state_next = lrpsb_pkg::ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default: begin
                state_next = lrpsb_pkg::ST_IDLE;
            end
        endcase
        if (dp_cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("output beat overwritten while stalled");

    a_show_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == lrpsb_pkg::CMD_SHOW))
        |=> (state_reg == lrpsb_pkg::ST_SHOW) && (cnt_reg == 4'd0))
        else $error("show run did not start at pixel 0");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= lrpsb_pkg::LAST_PIXEL_IDX)
        else $error("pixel counter out of range");

    a_last_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.emit && dp_cmd.last) |=> (state_reg == lrpsb_pkg::ST_IDLE) && m_valid_reg)
        else $error("show run did not end after last beat");

endmodule

// ----- hw/rtl/lrpsb_datapath.sv -----
// Datapath: twelve pixel color registers, command update logic and output register.
module lrpsb_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  lrpsb_pkg::dp_cmd_t dp_cmd,
    input  logic [3:0]         s_command,
    input  logic [3:0]         s_pixel_index,
    input  logic [31:0]        s_new_color,
    output logic [3:0]         m_out_index,
    output logic [31:0]        m_out_color,
    output logic               m_last_pixel
);

    lrpsb_pkg::pix_arr_t pix_reg, pix_next;
    logic [3:0]          out_index_reg;
    logic [31:0]         out_color_reg;
    logic                out_last_reg;

    function automatic lrpsb_pkg::color_t pick(lrpsb_pkg::pix_arr_t pix,
                                               lrpsb_pkg::src_map_t map,
                                               int unsigned p,
                                               lrpsb_pkg::color_t c);
        lrpsb_pkg::color_t r;
        if (map[p] == lrpsb_pkg::SRC_NEW) begin
            r = c;
        end else begin
            r = pix[map[p]];
        end
        return r;
    endfunction

    // every pixel picks its new value from a fixed source per command
    always_comb begin
        for (int unsigned i = 0; i < lrpsb_pkg::NUM_PIXELS; i++) begin
            pix_next[i] = pix_reg[i];
            unique case (lrpsb_pkg::cmd_t'(s_command))
                lrpsb_pkg::CMD_CLEAR:       pix_next[i] = '0;
                lrpsb_pkg::CMD_SET: begin
                    if (s_pixel_index == 4'(i)) begin
                        pix_next[i] = s_new_color;
                    end
                end
                lrpsb_pkg::CMD_LINE_RIGHT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::LINE_RIGHT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_LINE_LEFT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::LINE_LEFT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_COLS_RIGHT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::COLS_RIGHT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_COLS_LEFT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::COLS_LEFT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_DIGIT_RIGHT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::DIGIT_RIGHT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_DIGIT_LEFT:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::DIGIT_LEFT_MAP, i, s_new_color);
                lrpsb_pkg::CMD_ROWS_UP:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::ROWS_UP_MAP, i, s_new_color);
                lrpsb_pkg::CMD_ROWS_DOWN:
                    pix_next[i] = pick(pix_reg, lrpsb_pkg::ROWS_DOWN_MAP, i, s_new_color);
                default:                    pix_next[i] = pix_reg[i];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int unsigned i = 0; i < lrpsb_pkg::NUM_PIXELS; i++) begin
                pix_reg[i] <= '0;
            end
        end else if (dp_cmd.apply) begin
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            out_index_reg <= dp_cmd.index;
            out_color_reg <= pix_reg[dp_cmd.index];
            out_last_reg  <= dp_cmd.last;
        end
    end

    assign m_out_index  = out_index_reg;
    assign m_out_color  = out_color_reg;
    assign m_last_pixel = out_last_reg;

endmodule

// ----- hw/rtl/led_ring_pixel_shift_buffer_unit.sv -----
// Top level of the LED ring pixel shift buffer: controller plus datapath.
//
// Input channel (s_*): one command beat per accepted item; s_command selects
// clear, set pixel, line shift, column/digit/row group shift or show.
// s_pixel_index and s_new_color carry the operands.
// Result channel (m_*): only a show command produces beats, twelve of them,
// pixel 0 to 11 in order, with m_last_pixel high on pixel 11.
// Every command except show is accepted and applied in the cycle it is
// taken, so such commands stream at one per cycle while no show run is in
// progress; the twelve pixel registers update in parallel in that cycle.
// During a show the pixel counter in the controller loads one beat per
// cycle into the output register whenever it is empty or being read. No new
// command is taken until the last beat is loaded into the output register;
// the next command may be taken while that beat still waits.
// When m_ready is low the output register holds its beat and the show run
// pauses. Reset (aresetn low, synchronous) clears all pixels to zero and
// empties the output register.
module led_ring_pixel_shift_buffer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [3:0]  s_pixel_index,
    input  logic [31:0] s_new_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_out_index,
    output logic [31:0] m_out_color,
    output logic        m_last_pixel
);

    lrpsb_pkg::dp_cmd_t dp_cmd;

    lrpsb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_cmd    (dp_cmd)
    );

    lrpsb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dp_cmd        (dp_cmd),
        .s_command     (s_command),
        .s_pixel_index (s_pixel_index),
        .s_new_color   (s_new_color),
        .m_out_index   (m_out_index),
        .m_out_color   (m_out_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule
